[src/command_frame_builder_with_sum_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the command frame builder
// Shared concurrent assertion wrappers, clocked on the block clock.
// ---------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_WITH_SUM_TOP_ASSERT_SVH
`define COMMAND_FRAME_BUILDER_WITH_SUM_TOP_ASSERT_SVH

// checked at every edge outside reset
`define CFBS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cfbs assertion failed");

// checked at every edge, reset included
`define CFBS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("cfbs assertion failed");

`endif

[src/cfbs_pkg.sv]
// ---------------------------------------------------------------------------
// cfbs_pkg
// Constants, slot codes and shared types of the command frame builder.
// ---------------------------------------------------------------------------
package cfbs_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h57;
   localparam logic [7:0] HDR_SECOND = 8'hAB;

   // emission slots of one item, in send order
   localparam int NUM_SLOTS = 7;
   localparam logic [2:0] SLOT_HDR0 = 3'd0;
   localparam logic [2:0] SLOT_HDR1 = 3'd1;
   localparam logic [2:0] SLOT_ADDR = 3'd2;
   localparam logic [2:0] SLOT_CMD  = 3'd3;
   localparam logic [2:0] SLOT_LEN  = 3'd4;
   localparam logic [2:0] SLOT_PAY  = 3'd5;
   localparam logic [2:0] SLOT_SUM  = 3'd6;

   typedef logic [NUM_SLOTS-1:0] slot_mask_type;

   // item held while its bytes go out
   typedef struct packed {
      logic [7:0] address;
      logic [7:0] command;
      logic [7:0] length;
      logic [7:0] payload;
   } item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       is_checksum;
      logic       run_last;
   } emit_type;

   function automatic logic [7:0] table_length(input logic [7:0] cmd);
      logic [7:0] len;
      case (cmd)
         8'h02:   len = 8'h08;
         8'h03:   len = 8'h04;
         8'h04:   len = 8'h07;
         8'h05:   len = 8'h05;
         8'h0A:   len = 8'h01;
         8'h09:   len = 8'h32;
         default: len = 8'h00;
      endcase
      return len;
   endfunction

endpackage

[src/cfbs_seq.sv]
// ---------------------------------------------------------------------------
// cfbs_seq
// Picks the next pending slot of the held item, forms its byte and the
// updated running sum.
// ---------------------------------------------------------------------------
module cfbs_seq
   import cfbs_pkg::*;
(
   input  slot_mask_type mask,
   input  item_type      item,
   input  logic [7:0]    sum,
   output slot_mask_type sel,
   output emit_type      emit,
   output logic [7:0]    sum_next
);

   logic [2:0] idx;
   logic [7:0] data;

   // lowest pending slot goes first
   assign sel = mask & (~mask + slot_mask_type'(1));

   always_comb begin
      idx = SLOT_HDR0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = 3'(i);
         end
      end
   end

   always_comb begin
      case (idx)
         SLOT_HDR0: data = HDR_FIRST;
         SLOT_HDR1: data = HDR_SECOND;
         SLOT_ADDR: data = item.address;
         SLOT_CMD:  data = item.command;
         SLOT_LEN:  data = item.length;
         SLOT_PAY:  data = item.payload;
         SLOT_SUM:  data = sum;
         default:   data = 8'h00;
      endcase
   end

   always_comb begin
      case (idx)
         SLOT_HDR0: sum_next = HDR_FIRST;   // new frame restarts the sum
         SLOT_SUM:  sum_next = 8'h00;
         default:   sum_next = sum + data;
      endcase
   end

   assign emit.tx_byte     = data;
   assign emit.is_checksum = (idx == SLOT_SUM);
   assign emit.run_last    = ((mask & ~sel) == '0);

endmodule

[src/command_frame_builder_with_sum_top.sv]
// ---------------------------------------------------------------------------
// command_frame_builder_with_sum_top
// Builds serial command frames with a closing 8-bit additive checksum.
// ---------------------------------------------------------------------------
// Each accepted word is held in an item register with a mask of the bytes it
// owes (five header bytes when it opens a frame, its payload byte, the sum
// byte when it closes the frame); a word emits 0 to 7 bytes. One byte leaves
// per cycle into the response register unless rsp_ready holds it off. The
// next word is taken in the same cycle the current word's last byte moves
// into the response register, so a stream of payload-only words runs at one
// word per cycle while rsp_ready stays high. csr_wr_data sets the device
// address byte of later headers.
module command_frame_builder_with_sum_top
   import cfbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_command_code,
   input  logic [7:0] req_length_override,
   input  logic [7:0] req_payload_byte,
   input  logic       req_has_payload,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_is_checksum,
   output logic       rsp_run_last
);

`include "command_frame_builder_with_sum_top_assert.svh"

   logic [7:0]    addr_ff;
   logic          in_frame_ff, in_frame_in;
   logic [7:0]    sum_ff, sum_in;
   slot_mask_type mask_ff, mask_in;
   item_type      item_ff, item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   emit_type      rsp_ff, rsp_in;

   slot_mask_type sel;
   emit_type      emit;
   logic [7:0]    sum_next;
   logic          accept, advance;
   slot_mask_type new_mask;

   cfbs_seq u_seq (
      .mask     (mask_ff),
      .item     (item_ff),
      .sum      (sum_ff),
      .sel      (sel),
      .emit     (emit),
      .sum_next (sum_next)
   );

   assign advance   = (mask_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (mask_ff == '0) || (advance && emit.run_last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      new_mask                       = '0;
      new_mask[SLOT_LEN:SLOT_HDR0]   = {5{!in_frame_ff}};
      new_mask[SLOT_PAY]             = req_has_payload;
      new_mask[SLOT_SUM]             = req_frame_end;

      item_in.address = addr_ff;
      item_in.command = req_command_code;
      item_in.length  = (req_length_override != 8'h00) ? req_length_override
                                                       : table_length(req_command_code);
      item_in.payload = req_payload_byte;

      mask_in     = mask_ff;
      in_frame_in = in_frame_ff;
      sum_in      = sum_ff;
      if (advance) begin
         mask_in = mask_ff & ~sel;
         sum_in  = sum_next;
      end
      if (accept) begin
         mask_in     = new_mask;
         in_frame_in = !req_frame_end;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= 8'h00;
         in_frame_ff  <= 1'b0;
         sum_ff       <= 8'h00;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            addr_ff <= csr_wr_data;
         end
         in_frame_ff  <= in_frame_in;
         sum_ff       <= sum_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_byte     = rsp_ff.tx_byte;
   assign rsp_is_checksum = rsp_ff.is_checksum;
   assign rsp_run_last    = rsp_ff.run_last;

   // the sum byte always closes its word's output
   `CFBS_ASSERT(a_sum_is_last, clock, reset, rsp_valid_ff && rsp_ff.is_checksum |-> rsp_ff.run_last)
   // a word opening a frame owes the full header
   `CFBS_ASSERT(a_hdr_loaded, clock, reset, accept && !in_frame_ff |=> mask_ff[SLOT_LEN:SLOT_HDR0] == 5'h1F)
   // sending the sum clears it for the next frame
   `CFBS_ASSERT(a_sum_cleared, clock, reset, advance && emit.is_checksum |=> sum_ff == 8'h00)
   // nothing owed means the input side is open
   `CFBS_ASSERT_ALWAYS(a_ready_when_empty, clock, mask_ff == '0 |-> req_ready)

endmodule

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command frame builder: words are driven from a
// queue, each accepted word is run through a local frame predictor, and every
// output byte is compared against the oldest predicted byte.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cfbs_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_WORDS  = 40;

   // command -> length lookup, same order in both vectors
   localparam logic [5:0][7:0] KNOWN_CMD = {8'h02, 8'h03, 8'h04, 8'h05, 8'h0A, 8'h09};
   localparam logic [5:0][7:0] KNOWN_LEN = {8'h08, 8'h04, 8'h07, 8'h05, 8'h01, 8'h32};

   typedef struct {
      logic [7:0] command_code;
      logic [7:0] length_override;
      logic [7:0] payload_byte;
      logic       has_payload;
      logic       frame_end;
      logic       hold_for_drain;
   } word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_command_code = 8'h00;
   logic [7:0] req_length_override = 8'h00;
   logic [7:0] req_payload_byte = 8'h00;
   logic       req_has_payload = 1'b0;
   logic       req_frame_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_is_checksum;
   logic       rsp_run_last;

   word_type   word_q[$];
   emit_type   bytes_due[$];
   int         words_queued = 0;
   int         words_taken = 0;
   int         err_cnt = 0;
   logic       req_fire = 1'b0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         hold_left = 0;
   bit         hold_arm = 1'b0;

   // frame predictor state
   logic       frame_open = 1'b0;
   logic [7:0] frame_sum = 8'h00;
   logic [7:0] frame_addr = 8'h00;

   command_frame_builder_with_sum_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command_code    (req_command_code),
      .req_length_override (req_length_override),
      .req_payload_byte    (req_payload_byte),
      .req_has_payload     (req_has_payload),
      .req_frame_end       (req_frame_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_is_checksum     (rsp_is_checksum),
      .rsp_run_last        (rsp_run_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] lookup_length(input logic [7:0] cmd);
      logic [7:0] len;
      len = 8'h00;
      for (int i = 0; i < 6; i++) begin
         if (KNOWN_CMD[i] == cmd) len = KNOWN_LEN[i];
      end
      return len;
   endfunction

   // bytes one accepted word puts on the line, pushed onto bytes_due
   task automatic predict_word(input word_type w);
      logic [7:0] line[$];
      emit_type   e;
      if (!frame_open) begin
         frame_sum = 8'h00;
         line.push_back(HDR_FIRST);
         line.push_back(HDR_SECOND);
         line.push_back(frame_addr);
         line.push_back(w.command_code);
         line.push_back(w.length_override != 8'h00 ? w.length_override
                                                   : lookup_length(w.command_code));
         frame_open = 1'b1;
      end
      if (w.has_payload) line.push_back(w.payload_byte);
      foreach (line[i]) begin
         frame_sum = frame_sum + line[i];
         e.tx_byte = line[i];
         e.is_checksum = 1'b0;
         e.run_last = (i == line.size() - 1) && !w.frame_end;
         bytes_due.push_back(e);
      end
      if (w.frame_end) begin
         e.tx_byte = frame_sum;
         e.is_checksum = 1'b1;
         e.run_last = 1'b1;
         bytes_due.push_back(e);
         frame_open = 1'b0;
         frame_sum = 8'h00;
      end
   endtask

   // monitor: checks output bytes, feeds the predictor on accepted words
   always @(posedge clock) begin
      emit_type want;
      word_type w;
      if (reset) begin
         frame_open = 1'b0;
         frame_sum = 8'h00;
         frame_addr = 8'h00;
         req_fire <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bytes_due.size() == 0) begin
               $error("unexpected rsp word: tx_byte %02h is_checksum %0b run_last %0b",
                      rsp_tx_byte, rsp_is_checksum, rsp_run_last);
               err_cnt++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_tx_byte !== want.tx_byte) begin
                  $error("tx_byte: expected %02h, actual %02h", want.tx_byte, rsp_tx_byte);
                  err_cnt++;
               end
               if (rsp_is_checksum !== want.is_checksum) begin
                  $error("is_checksum: expected %0b, actual %0b",
                         want.is_checksum, rsp_is_checksum);
                  err_cnt++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("run_last: expected %0b, actual %0b", want.run_last, rsp_run_last);
                  err_cnt++;
               end
            end
         end
         if (req_valid && req_ready) begin
            w.command_code = req_command_code;
            w.length_override = req_length_override;
            w.payload_byte = req_payload_byte;
            w.has_payload = req_has_payload;
            w.frame_end = req_frame_end;
            w.hold_for_drain = 1'b0;
            predict_word(w);
            words_taken++;
         end
         if (csr_wr_en) frame_addr = csr_wr_data;
         req_fire <= req_valid && req_ready;
      end
   end

   // driver
   always @(negedge clock) begin
      word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (word_q.size() != 0 && !(word_q[0].hold_for_drain && bytes_due.size() != 0)
             && $urandom_range(99) >= send_idle_pct) begin
            w = word_q.pop_front();
            req_valid <= 1'b1;
            req_command_code <= w.command_code;
            req_length_override <= w.length_override;
            req_payload_byte <= w.payload_byte;
            req_has_payload <= w.has_payload;
            req_frame_end <= w.frame_end;
         end else begin
            req_valid <= 1'b0;
            req_command_code <= 8'($urandom);
            req_length_override <= 8'($urandom);
            req_payload_byte <= 8'($urandom);
            req_has_payload <= 1'($urandom_range(1));
            req_frame_end <= 1'($urandom_range(1));
         end
      end
   end

   // receiver, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_arm) begin
         hold_arm = 1'b0;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= rsp_stall_pct;
      end
   end

   task automatic queue_word(input logic [7:0] cmd, input logic [7:0] ovr,
                             input logic [7:0] pay, input logic has, input logic fin,
                             input logic hold = 1'b0);
      word_type w;
      w.command_code = cmd;
      w.length_override = ovr;
      w.payload_byte = pay;
      w.has_payload = has;
      w.frame_end = fin;
      w.hold_for_drain = hold;
      word_q.push_back(w);
      words_queued++;
   endtask

   function automatic logic [7:0] pick_command();
      int r;
      r = $urandom_range(9);
      if (r < 6) return KNOWN_CMD[r];
      if (r == 6) return 8'h00;
      if (r == 7) return 8'hFF;
      return 8'($urandom);
   endfunction

   // mostly well-formed frames with random content, the rest loose words
   task automatic queue_random_words(input int target);
      int made;
      int body;
      made = 0;
      while (made < target) begin
         if ($urandom_range(99) < 75) begin
            body = $urandom_range(0, 4);
            queue_word(pick_command(), $urandom_range(1) ? 8'h00 : 8'($urandom),
                       8'($urandom), 1'($urandom_range(1)),
                       body == 0 ? 1'($urandom_range(1)) : 1'b0,
                       $urandom_range(99) < 3);
            for (int i = 1; i < body; i++) begin
               queue_word(8'($urandom), 8'($urandom), 8'($urandom),
                          $urandom_range(9) != 0, 1'b0);
            end
            if (body != 0) begin
               queue_word(8'($urandom), 8'($urandom), 8'($urandom),
                          1'($urandom_range(1)), 1'b1);
            end
            made += (body == 0) ? 1 : body + 1;
         end else begin
            queue_word(8'($urandom), 8'($urandom), 8'($urandom),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
            made++;
         end
      end
   endtask

   task automatic write_address(input logic [7:0] addr);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= addr;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait for all words taken and all bytes seen, plus a margin for a word
   // that emits nothing
   task automatic settle();
      do @(negedge clock);
      while (words_taken != words_queued || bytes_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      int idle_pct[4][2];
      logic [7:0] next_addr[4];
      idle_pct = '{'{0, 0}, '{48, 0}, '{0, 48}, '{18, 18}};
      next_addr = '{8'hFF, 8'h5A, 8'h80, 8'h01};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_address(8'hFF);
      queue_word(8'h02, 8'h00, 8'h00, 1'b0, 1'b1);   // empty frame
      queue_word(8'h03, 8'h00, 8'h11, 1'b1, 1'b1);
      queue_word(8'h04, 8'h00, 8'h22, 1'b1, 1'b1);
      queue_word(8'h05, 8'h00, 8'h33, 1'b1, 1'b1);
      queue_word(8'h0A, 8'h00, 8'h44, 1'b1, 1'b1);
      queue_word(8'h09, 8'h00, 8'h55, 1'b1, 1'b1);
      queue_word(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1);   // unknown command, length 0
      queue_word(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
      queue_word(8'hFF, 8'hFF, 8'h12, 1'b0, 1'b0);   // no bytes at all
      queue_word(8'h5A, 8'h01, 8'hFF, 1'b1, 1'b0);
      queue_word(8'h00, 8'h00, 8'h80, 1'b1, 1'b0);
      queue_word(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
      queue_word(8'h09, 8'h01, 8'h00, 1'b0, 1'b0);   // header only
      queue_word(8'h00, 8'h00, 8'hAA, 1'b1, 1'b0);
      queue_word(8'h00, 8'h00, 8'h55, 1'b1, 1'b1);
      queue_word(8'h02, 8'h80, 8'h7F, 1'b1, 1'b0);   // override beats table
      queue_word(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      queue_word(8'h00, 8'h00, 8'h01, 1'b1, 1'b1);
      queue_word(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
      queue_word(8'h03, 8'h00, 8'hC3, 1'b1, 1'b0);   // left open across the write
      settle();

      // address change with a frame open: only later headers see it
      write_address(8'h00);
      queue_word(8'hEE, 8'hEE, 8'h3C, 1'b1, 1'b0);
      queue_word(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_pct[p][0];
         rsp_stall_pct = idle_pct[p][1];
         queue_random_words(PHASE_WORDS);
         settle();
         write_address(p == 2 ? 8'($urandom) : next_addr[p]);
      end

      // long receiver hold-off with the sender pushing, then a drain pause
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_arm = 1'b1;
      queue_random_words(25);
      queue_word(8'h04, 8'h00, 8'h9E, 1'b1, 1'b0, 1'b1);
      queue_word(8'h00, 8'h00, 8'h61, 1'b1, 1'b1);
      queue_random_words(15);
      settle();

      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #200_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
